// ----- sv/xie_pkg.sv -----
package xie_pkg;

    // default width of the running byte counter
    localparam int OFFSET_BITS_DEF = 16;
    // longest instruction in bytes and the width of a length field
    localparam int MAX_BYTES = 14;
    localparam int LEN_W = 4;
    // width of the offset field on the result port
    localparam int CODE_OFFSET_W = 16;
    // depth of the queue between front and back
    localparam int Q_DEPTH = 2;

    // request codes
    typedef enum logic [4:0] {
        OP_PUSH      = 5'd0,
        OP_POP       = 5'd1,
        OP_MOV_IMM64 = 5'd2,
        OP_MOV_RR    = 5'd3,
        OP_TEST_RR   = 5'd4,
        OP_CMP_RR    = 5'd5,
        OP_XOR_RR    = 5'd6,
        OP_LOAD      = 5'd7,
        OP_STORE     = 5'd8,
        OP_MOVUPS_LD = 5'd9,
        OP_MOVUPS_ST = 5'd10,
        OP_MOVQ_LD   = 5'd11,
        OP_MOVQ_ST   = 5'd12,
        OP_MOV_MI32  = 5'd13,
        OP_ADD_I32   = 5'd14,
        OP_SUB_I32   = 5'd15,
        OP_CMP_MI32  = 5'd16,
        OP_INC_MEM   = 5'd17,
        OP_CALL_R    = 5'd18,
        OP_JMP_REL   = 5'd19,
        OP_JCC_REL   = 5'd20,
        OP_JMP_ABS   = 5'd21,
        OP_PAUSE     = 5'd22,
        OP_RET       = 5'd23,
        OP_INT3      = 5'd24,
        OP_CLEAR     = 5'd25
    } op_t;

    // one instruction request
    typedef struct packed {
        logic [4:0]         req_type;
        logic [3:0]         reg_first;
        logic [3:0]         reg_second;
        logic [2:0]         xmm_number;
        logic signed [31:0] displacement;
        logic [63:0]        immediate;
        logic [7:0]         condition;
    } req_t;

    // one byte of machine code
    typedef struct packed {
        logic [7:0]               code_byte;
        logic [CODE_OFFSET_W-1:0] code_offset;
        logic                     final_byte;
    } res_t;

    // encoded instruction as it sits in the queue
    typedef struct packed {
        logic [MAX_BYTES-1:0][7:0] bytes;
        logic [LEN_W-1:0]          len;
        logic                      clr;
    } ins_t;

endpackage

// ----- sv/xie_front.sv -----
module xie_front import xie_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    output logic full,
    input  req_t req,
    output logic q_wr,
    output ins_t q_wdata,
    input  logic q_full
);

    // ModRM, optional SIB and displacement for a base plus displacement operand
    typedef struct packed {
        logic [5:0][7:0] b;
        logic [2:0]      n;
    } mem_t;

    typedef struct packed {
        ins_t ins;
        logic vld;
    } enc_t;

    function automatic mem_t modrm_mem(input logic [2:0] regf, input logic [3:0] base,
                                       input logic [31:0] disp);
        mem_t       m;
        logic [2:0] bi;
        logic [1:0] md;
        logic       fits8;
        bi    = base[2:0];
        fits8 = (disp[31:7] == 25'h0) || (disp[31:7] == 25'h1FFFFFF);
        if (disp == 32'h0 && bi != 3'd5)
            md = 2'b00;
        else if (fits8)
            md = 2'b01;
        else
            md = 2'b10;
        m.b = '0;
        m.b[0] = {md, regf, bi};
        m.n = 3'd1;
        // sib for rsp or r12 base
        if (bi == 3'd4)
        begin
            m.b[m.n] = 8'h24;
            m.n = m.n + 3'd1;
        end
        if (md == 2'b01)
        begin
            m.b[m.n] = disp[7:0];
            m.n = m.n + 3'd1;
        end
        else if (md == 2'b10)
        begin
            m.b[m.n]        = disp[7:0];
            m.b[m.n + 3'd1] = disp[15:8];
            m.b[m.n + 3'd2] = disp[23:16];
            m.b[m.n + 3'd3] = disp[31:24];
            m.n = m.n + 3'd4;
        end
        return m;
    endfunction

    function automatic logic [7:0] rex(input logic r, input logic bb);
        return {5'b01001, r, 1'b0, bb};
    endfunction

    // classify a request and lay down its bytes: prefix/opcode, memory operand, tail
    function automatic enc_t encode(input req_t q);
        enc_t                 e;
        logic [2:0][7:0]      p;
        logic [1:0]           pn;
        logic                 use_mem;
        logic [2:0]           mreg;
        mem_t                 m;
        logic [11:0][7:0]     t;
        logic [LEN_W-1:0]     tn;
        logic [LEN_W-1:0]     n;
        logic [3:0]           r1;
        logic [3:0]           r2;
        logic [31:0]          disp;
        p       = '0;
        pn      = 2'd1;
        use_mem = 1'b0;
        mreg    = q.xmm_number;
        t       = '0;
        tn      = '0;
        r1      = q.reg_first;
        r2      = q.reg_second;
        disp    = q.displacement;
        e       = '0;
        e.vld   = 1'b1;
        case (op_t'(q.req_type))
            OP_PUSH, OP_POP:
            begin
                if (r1[3])
                begin
                    p[0] = 8'h41;
                    p[1] = {4'h5, op_t'(q.req_type) == OP_POP, r1[2:0]};
                    pn   = 2'd2;
                end
                else
                    p[0] = {4'h5, op_t'(q.req_type) == OP_POP, r1[2:0]};
            end
            OP_MOV_IMM64:
            begin
                p[0] = {7'b0100100, r1[3]};
                p[1] = {5'b10111, r1[2:0]};
                pn   = 2'd2;
                t    = {32'h0, q.immediate};
                tn   = 4'd8;
            end
            OP_MOV_RR, OP_TEST_RR, OP_CMP_RR, OP_XOR_RR:
            begin
                p[0] = rex(r2[3], r1[3]);
                case (op_t'(q.req_type))
                    OP_MOV_RR:  p[1] = 8'h89;
                    OP_TEST_RR: p[1] = 8'h85;
                    OP_CMP_RR:  p[1] = 8'h39;
                    default:    p[1] = 8'h31;
                endcase
                p[2] = {2'b11, r2[2:0], r1[2:0]};
                pn   = 2'd3;
            end
            OP_LOAD:
            begin
                p[0]    = rex(r1[3], r2[3]);
                p[1]    = 8'h8B;
                pn      = 2'd2;
                use_mem = 1'b1;
                mreg    = r1[2:0];
            end
            OP_STORE:
            begin
                p[0]    = rex(r2[3], r1[3]);
                p[1]    = 8'h89;
                pn      = 2'd2;
                use_mem = 1'b1;
                mreg    = r2[2:0];
            end
            OP_MOVUPS_LD, OP_MOVUPS_ST:
            begin
                p[0]    = 8'h0F;
                p[1]    = (op_t'(q.req_type) == OP_MOVUPS_LD) ? 8'h10 : 8'h11;
                pn      = 2'd2;
                use_mem = 1'b1;
            end
            OP_MOVQ_LD:
            begin
                p[0]    = 8'hF3;
                p[1]    = 8'h0F;
                p[2]    = 8'h7E;
                pn      = 2'd3;
                use_mem = 1'b1;
            end
            OP_MOVQ_ST:
            begin
                p[0]    = 8'h66;
                p[1]    = 8'h0F;
                p[2]    = 8'hD6;
                pn      = 2'd3;
                use_mem = 1'b1;
            end
            OP_MOV_MI32, OP_CMP_MI32:
            begin
                p[0]    = rex(1'b0, r1[3]);
                p[1]    = (op_t'(q.req_type) == OP_MOV_MI32) ? 8'hC7 : 8'h81;
                pn      = 2'd2;
                use_mem = 1'b1;
                mreg    = (op_t'(q.req_type) == OP_MOV_MI32) ? 3'd0 : 3'd7;
                t       = {64'h0, q.immediate[31:0]};
                tn      = 4'd4;
            end
            OP_ADD_I32, OP_SUB_I32:
            begin
                p[0] = {7'b0100100, r1[3]};
                p[1] = 8'h81;
                p[2] = (op_t'(q.req_type) == OP_ADD_I32) ? {5'b11000, r1[2:0]}
                                                          : {5'b11101, r1[2:0]};
                pn   = 2'd3;
                t    = {64'h0, q.immediate[31:0]};
                tn   = 4'd4;
            end
            OP_INC_MEM:
            begin
                p[0]    = rex(1'b0, r1[3]);
                p[1]    = 8'hFF;
                pn      = 2'd2;
                use_mem = 1'b1;
                mreg    = 3'd0;
            end
            OP_CALL_R:
            begin
                if (r1[3])
                begin
                    p[0] = 8'h41;
                    p[1] = 8'hFF;
                    p[2] = {5'b11010, r1[2:0]};
                    pn   = 2'd3;
                end
                else
                begin
                    p[0] = 8'hFF;
                    p[1] = {5'b11010, r1[2:0]};
                    pn   = 2'd2;
                end
            end
            OP_JMP_REL:
            begin
                p[0] = 8'hE9;
                t    = {64'h0, disp};
                tn   = 4'd4;
            end
            OP_JCC_REL:
            begin
                p[0] = 8'h0F;
                p[1] = {4'h8, q.condition[3:0]};
                pn   = 2'd2;
                t    = {64'h0, disp};
                tn   = 4'd4;
            end
            OP_JMP_ABS:
            begin
                p[0] = 8'hFF;
                p[1] = 8'h25;
                pn   = 2'd2;
                t    = {q.immediate, 32'h0};
                tn   = 4'd12;
            end
            OP_PAUSE:
            begin
                p[0] = 8'hF3;
                p[1] = 8'h90;
                pn   = 2'd2;
            end
            OP_RET:   p[0] = 8'hC3;
            OP_INT3:  p[0] = 8'hCC;
            OP_CLEAR: e.ins.clr = 1'b1;
            default:  e.vld = 1'b0;
        endcase
        m = modrm_mem(mreg, r1, disp);
        if (op_t'(q.req_type) == OP_LOAD)
            m = modrm_mem(mreg, r2, disp);
        // assemble prefix, memory operand and tail
        for (int i = 0; i < 3; i++)
            if (2'(i) < pn)
                e.ins.bytes[i] = p[i];
        n = {2'b00, pn};
        if (use_mem)
        begin
            for (int i = 0; i < 6; i++)
                if (3'(i) < m.n)
                    e.ins.bytes[n + 4'(i)] = m.b[i];
            n = n + {1'b0, m.n};
        end
        for (int i = 0; i < 12; i++)
            if (4'(i) < tn)
                e.ins.bytes[n + 4'(i)] = t[i];
        n = n + tn;
        e.ins.len = e.ins.clr ? '0 : n;
        return e;
    endfunction

    logic stg_valid_reg;
    logic stg_valid_next;
    req_t stg_reg;
    enc_t enc;
    logic move;
    logic accept;

    // encode the staged request
    assign enc     = encode(stg_reg);
    assign move    = stg_valid_reg && (!q_full || !enc.vld);
    assign full    = stg_valid_reg && !move;
    assign accept  = push && !full;
    assign q_wr    = stg_valid_reg && enc.vld && !q_full;
    assign q_wdata = enc.ins;

    // staging register valid
    always_comb
    begin
        stg_valid_next = stg_valid_reg;
        if (accept)
            stg_valid_next = 1'b1;
        else if (move)
            stg_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            stg_valid_reg <= 1'b0;
        else
            stg_valid_reg <= stg_valid_next;
    end

    // request payload capture
    always_ff @(posedge clk)
    begin
        if (accept)
            stg_reg <= req;
    end

endmodule

// ----- sv/xie_queue.sv -----
module xie_queue import xie_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic wr,
    input  ins_t wdata,
    output logic q_full,
    input  logic rd,
    output ins_t rdata,
    output logic q_vld
);

    localparam int PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int CNT_W = $clog2(Q_DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(Q_DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(Q_DEPTH);

    ins_t             slot_reg [Q_DEPTH];
    logic [PTR_W-1:0] wp_reg;
    logic [PTR_W-1:0] wp_next;
    logic [PTR_W-1:0] rp_reg;
    logic [PTR_W-1:0] rp_next;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    logic             do_wr;
    logic             do_rd;

    assign q_full = (cnt_reg == CNT_FULL);
    assign q_vld  = (cnt_reg != '0);
    assign do_wr  = wr && !q_full;
    assign do_rd  = rd && q_vld;
    assign rdata  = slot_reg[rp_reg];

    // pointer and fill count update
    always_comb
    begin
        wp_next  = wp_reg;
        rp_next  = rp_reg;
        cnt_next = cnt_reg;
        if (do_wr)
            wp_next = (wp_reg == PTR_LAST) ? '0 : wp_reg + PTR_W'(1);
        if (do_rd)
            rp_next = (rp_reg == PTR_LAST) ? '0 : rp_reg + PTR_W'(1);
        if (do_wr && !do_rd)
            cnt_next = cnt_reg + CNT_W'(1);
        else if (do_rd && !do_wr)
            cnt_next = cnt_reg - CNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (do_wr)
            slot_reg[wp_reg] <= wdata;
    end

    // fill count stays within depth
    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_FULL)
        else $error("queue fill count beyond depth");

    // a lone transfer in moves the fill count up by one
    a_cnt_up: assert property (@(posedge clk) disable iff (!rst_n)
        (do_wr && !do_rd) |=> cnt_reg == $past(cnt_reg) + CNT_W'(1))
        else $error("queue fill count missed a write");

    // pointers agree with the fill count when empty
    a_ptr_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg == '0) |-> (wp_reg == rp_reg))
        else $error("queue pointers disagree while empty");

endmodule

// ----- sv/xie_back.sv -----
module xie_back import xie_pkg::*;
#(
    parameter int OFFSET_BITS = OFFSET_BITS_DEF
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic q_vld,
    input  ins_t q_data,
    output logic q_rd,
    output logic empty,
    input  logic pop,
    output res_t res
);

    localparam logic [OFFSET_BITS-1:0] CNT_ONE = OFFSET_BITS'(1);

    ins_t                   cur_reg;
    logic                   cur_valid_reg;
    logic                   cur_valid_next;
    logic [LEN_W-1:0]       idx_reg;
    logic [LEN_W-1:0]       idx_next;
    logic [OFFSET_BITS-1:0] cnt_reg;
    logic [OFFSET_BITS-1:0] cnt_next;
    res_t                   out_reg;
    logic                   out_valid_reg;
    logic                   out_valid_next;
    logic [CODE_OFFSET_W-1:0] offs;
    logic                   adv;
    logic                   emit;
    logic                   last;
    logic                   take_clr;
    logic                   take_ins;

    // offset field from the running counter
    if (OFFSET_BITS >= CODE_OFFSET_W)
    begin : g_offs_wide
        assign offs = cnt_reg[CODE_OFFSET_W-1:0];
    end
    else
    begin : g_offs_narrow
        assign offs = {{(CODE_OFFSET_W-OFFSET_BITS){1'b0}}, cnt_reg};
    end

    // byte stepping and queue reads
    assign adv      = !out_valid_reg || pop;
    assign emit     = cur_valid_reg && adv;
    assign last     = (idx_reg == cur_reg.len - LEN_W'(1));
    assign take_clr = q_vld && q_data.clr && !cur_valid_reg;
    assign take_ins = q_vld && !q_data.clr && (!cur_valid_reg || (emit && last));
    assign q_rd     = take_clr || take_ins;
    assign empty    = !out_valid_reg;
    assign res      = out_reg;

    always_comb
    begin
        cur_valid_next = cur_valid_reg;
        idx_next       = idx_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg;
        if (emit && last)
            cur_valid_next = 1'b0;
        if (emit)
            idx_next = idx_reg + LEN_W'(1);
        if (take_ins)
        begin
            cur_valid_next = 1'b1;
            idx_next       = '0;
        end
        if (take_clr)
            cnt_next = '0;
        else if (emit)
            cnt_next = cnt_reg + CNT_ONE;
        if (emit)
            out_valid_next = 1'b1;
        else if (pop)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
            idx_reg       <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cur_valid_reg <= cur_valid_next;
            idx_reg       <= idx_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // instruction and result payload
    always_ff @(posedge clk)
    begin
        if (take_ins)
            cur_reg <= q_data;
        if (emit)
        begin
            out_reg.code_byte   <= cur_reg.bytes[idx_reg];
            out_reg.code_offset <= offs;
            out_reg.final_byte  <= last;
        end
    end

    // byte index stays inside the current instruction
    a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
        cur_valid_reg |-> idx_reg < cur_reg.len)
        else $error("byte index past instruction length");

    // every emitted byte advances the offset by one
    a_cnt_step: assert property (@(posedge clk) disable iff (!rst_n)
        emit |=> cnt_reg == $past(cnt_reg) + CNT_ONE)
        else $error("offset did not advance on emitted byte");

    // an offset clear never overlaps an instruction in flight
    a_clr_idle: assert property (@(posedge clk) disable iff (!rst_n)
        take_clr |-> !emit && !take_ins)
        else $error("offset clear overlaps byte output");

    // a non-final byte keeps the instruction in progress
    a_keep_cur: assert property (@(posedge clk) disable iff (!rst_n)
        (emit && !last) |=> cur_valid_reg)
        else $error("instruction dropped before its final byte");

endmodule

// ----- sv/x86_64_instruction_encoder_unit.sv -----
// a request passes the front staging register, a queue slot and the back instruction register
// before its first byte is registered on res; code bytes leave one per cycle unless pop stalls,
// a request has 1 to 14 bytes; the back part's serializer sets that rate; an offset clear
// is taken only while no instruction is in the back part, so it leaves a gap in the byte output
// unknown request codes are dropped in the front part without a result
// reset: asynchronous on rst_n low, all queues empty and the byte offset back to zero
module x86_64_instruction_encoder_unit import xie_pkg::*;
#(
    parameter int OFFSET_BITS = OFFSET_BITS_DEF
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    output logic full,
    input  req_t req,
    output logic empty,
    input  logic pop,
    output res_t res
);

    logic q_wr;
    ins_t q_wdata;
    logic q_full;
    logic q_rd;
    ins_t q_rdata;
    logic q_vld;

    // request staging and encoding
    xie_front u_front
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .full    (full),
        .req     (req),
        .q_wr    (q_wr),
        .q_wdata (q_wdata),
        .q_full  (q_full)
    );

    // encoded instructions waiting for output
    xie_queue u_queue
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .wr     (q_wr),
        .wdata  (q_wdata),
        .q_full (q_full),
        .rd     (q_rd),
        .rdata  (q_rdata),
        .q_vld  (q_vld)
    );

    // byte serializer with running offset
    xie_back #(
        .OFFSET_BITS (OFFSET_BITS)
    ) u_back
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .q_vld  (q_vld),
        .q_data (q_rdata),
        .q_rd   (q_rd),
        .empty  (empty),
        .pop    (pop),
        .res    (res)
    );

endmodule

// ----- bench/x86_code_monitor.sv -----
`timescale 1ns / 1ps

module x86_code_monitor import xie_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  logic full,
    input  req_t req,
    input  logic empty,
    input  logic pop,
    input  res_t res,
    output int   errors,
    output int   pending
);

    // modrm mod field values
    localparam logic [1:0] MOD_NO_DISP = 2'b00;
    localparam logic [1:0] MOD_DISP8   = 2'b01;
    localparam logic [1:0] MOD_DISP32  = 2'b10;
    localparam logic [1:0] MOD_REG     = 2'b11;
    // sib byte with base only, and the low base codes that need care
    localparam logic [7:0] SIB_BASE_ONLY = 8'h24;
    localparam logic [2:0] BASE_RSP      = 3'd4;
    localparam logic [2:0] BASE_RBP      = 3'd5;

    logic [7:0]               insn_bytes[$];
    res_t                     code_bytes_due[$];
    logic [CODE_OFFSET_W-1:0] buffer_offset;

    // append one byte to the instruction being built
    function automatic void add_byte(input logic [7:0] v);
        insn_bytes.insert(insn_bytes.size(), v);
    endfunction

    // little endian immediate or displacement
    function automatic void put_le(input logic [63:0] v, input int n);
        for (int i = 0; i < n; i++)
        begin
            add_byte(v[8*i +: 8]);
        end
    endfunction

    // rex.w with r from the reg field and b from the rm field
    function automatic logic [7:0] rex_for(input logic [3:0] regf, input logic [3:0] rm);
        return 8'h48 | {5'b0, regf[3], 1'b0, rm[3]};
    endfunction

    // rex, opcode and register-direct modrm
    function automatic void reg_reg(input logic [7:0] opc, input logic [3:0] dst,
                                    input logic [3:0] src);
        add_byte(rex_for(src, dst));
        add_byte(opc);
        add_byte({MOD_REG, src[2:0], dst[2:0]});
    endfunction

    // modrm for [base+disp], sib when the base is rsp or r12
    function automatic void mem_operand(input logic [2:0] regf, input logic [3:0] base,
                                        input logic [31:0] disp);
        logic [1:0] mode;
        mode = MOD_DISP32;
        if (disp == 32'd0 && base[2:0] != BASE_RBP)
            mode = MOD_NO_DISP;
        else if ($signed(disp) >= -128 && $signed(disp) <= 127)
            mode = MOD_DISP8;
        add_byte({mode, regf, base[2:0]});
        if (base[2:0] == BASE_RSP)
            add_byte(SIB_BASE_ONLY);
        if (mode == MOD_DISP8)
            add_byte(disp[7:0]);
        else if (mode == MOD_DISP32)
            put_le({32'd0, disp}, 4);
    endfunction

    // machine code of one request, queued byte by byte with offsets
    function automatic void encode_request(input req_t r);
        res_t b;
        insn_bytes.delete();
        case (r.req_type)
            OP_PUSH:
            begin
                if (r.reg_first[3])
                    add_byte(8'h41);
                add_byte(8'h50 + r.reg_first[2:0]);
            end
            OP_POP:
            begin
                if (r.reg_first[3])
                    add_byte(8'h41);
                add_byte(8'h58 + r.reg_first[2:0]);
            end
            OP_MOV_IMM64:
            begin
                add_byte(8'h48 | r.reg_first[3]);
                add_byte(8'hB8 + r.reg_first[2:0]);
                put_le(r.immediate, 8);
            end
            OP_MOV_RR:  reg_reg(8'h89, r.reg_first, r.reg_second);
            OP_TEST_RR: reg_reg(8'h85, r.reg_first, r.reg_second);
            OP_CMP_RR:  reg_reg(8'h39, r.reg_first, r.reg_second);
            OP_XOR_RR:  reg_reg(8'h31, r.reg_first, r.reg_second);
            OP_LOAD:
            begin
                add_byte(rex_for(r.reg_first, r.reg_second));
                add_byte(8'h8B);
                mem_operand(r.reg_first[2:0], r.reg_second, r.displacement);
            end
            OP_STORE:
            begin
                add_byte(rex_for(r.reg_second, r.reg_first));
                add_byte(8'h89);
                mem_operand(r.reg_second[2:0], r.reg_first, r.displacement);
            end
            // xmm forms carry no rex, so the base loses bit 3
            OP_MOVUPS_LD:
            begin
                put_le(64'h100F, 2);
                mem_operand(r.xmm_number, {1'b0, r.reg_first[2:0]}, r.displacement);
            end
            OP_MOVUPS_ST:
            begin
                put_le(64'h110F, 2);
                mem_operand(r.xmm_number, {1'b0, r.reg_first[2:0]}, r.displacement);
            end
            OP_MOVQ_LD:
            begin
                put_le(64'h7E0FF3, 3);
                mem_operand(r.xmm_number, {1'b0, r.reg_first[2:0]}, r.displacement);
            end
            OP_MOVQ_ST:
            begin
                put_le(64'hD60F66, 3);
                mem_operand(r.xmm_number, {1'b0, r.reg_first[2:0]}, r.displacement);
            end
            OP_MOV_MI32:
            begin
                add_byte(rex_for(4'd0, r.reg_first));
                add_byte(8'hC7);
                mem_operand(3'd0, r.reg_first, r.displacement);
                put_le(r.immediate, 4);
            end
            OP_ADD_I32:
            begin
                add_byte(8'h48 | r.reg_first[3]);
                add_byte(8'h81);
                add_byte(8'hC0 | r.reg_first[2:0]);
                put_le(r.immediate, 4);
            end
            OP_SUB_I32:
            begin
                add_byte(8'h48 | r.reg_first[3]);
                add_byte(8'h81);
                add_byte(8'hE8 | r.reg_first[2:0]);
                put_le(r.immediate, 4);
            end
            OP_CMP_MI32:
            begin
                add_byte(rex_for(4'd0, r.reg_first));
                add_byte(8'h81);
                mem_operand(3'd7, r.reg_first, r.displacement);
                put_le(r.immediate, 4);
            end
            OP_INC_MEM:
            begin
                add_byte(rex_for(4'd0, r.reg_first));
                add_byte(8'hFF);
                mem_operand(3'd0, r.reg_first, r.displacement);
            end
            OP_CALL_R:
            begin
                if (r.reg_first[3])
                    add_byte(8'h41);
                add_byte(8'hFF);
                add_byte(8'hD0 | r.reg_first[2:0]);
            end
            OP_JMP_REL:
            begin
                add_byte(8'hE9);
                put_le({32'd0, r.displacement}, 4);
            end
            // only the low nibble of the condition is used
            OP_JCC_REL:
            begin
                add_byte(8'h0F);
                add_byte(8'h80 | r.condition[3:0]);
                put_le({32'd0, r.displacement}, 4);
            end
            OP_JMP_ABS:
            begin
                put_le(64'h25FF, 6);
                put_le(r.immediate, 8);
            end
            OP_PAUSE: put_le(64'h90F3, 2);
            OP_RET:   add_byte(8'hC3);
            OP_INT3:  add_byte(8'hCC);
            OP_CLEAR: buffer_offset = '0;
            default:  ;
        endcase
        for (int n = 0; n < insn_bytes.size(); n++)
        begin
            b.code_byte   = insn_bytes[n];
            b.code_offset = buffer_offset;
            b.final_byte  = (n == insn_bytes.size() - 1);
            code_bytes_due.insert(code_bytes_due.size(), b);
            buffer_offset = buffer_offset + 1'b1;
        end
    endfunction

    // compare popped bytes, then predict the pushed request
    always @(posedge clk or negedge rst_n)
    begin : watch
        res_t want;
        if (!rst_n)
        begin
            code_bytes_due.delete();
            buffer_offset = '0;
            errors        = 0;
            pending       = 0;
        end
        else
        begin
            if (pop && !empty)
            begin
                if (code_bytes_due.size() == 0)
                begin
                    $display("%0t: unexpected code byte transfer, actual %h", $time, res);
                    errors++;
                end
                else
                begin
                    want = code_bytes_due.pop_front();
                    if (res.code_byte !== want.code_byte)
                    begin
                        $display("%0t: code_byte expected %h actual %h",
                                 $time, want.code_byte, res.code_byte);
                        errors++;
                    end
                    if (res.code_offset !== want.code_offset)
                    begin
                        $display("%0t: code_offset expected %h actual %h",
                                 $time, want.code_offset, res.code_offset);
                        errors++;
                    end
                    if (res.final_byte !== want.final_byte)
                    begin
                        $display("%0t: final_byte expected %b actual %b",
                                 $time, want.final_byte, res.final_byte);
                        errors++;
                    end
                end
            end
            if (push && !full)
                encode_request(req);
            pending = code_bytes_due.size();
        end
    end

endmodule

// ----- bench/tb.sv -----
`timescale 1ns / 1ps

module tb import xie_pkg::*;
;

    localparam int RANDOM_REQUESTS = 198;

    logic clk;
    logic rst_n;
    logic push;
    logic full;
    req_t req;
    logic empty;
    logic pop;
    res_t res;
    int   errors;
    int   pending;
    bit   sender_calm;
    bit   receiver_calm;

    x86_64_instruction_encoder_unit i_dut
    (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .full  (full),
        .req   (req),
        .empty (empty),
        .pop   (pop),
        .res   (res)
    );

    x86_code_monitor i_code_monitor
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .full    (full),
        .req     (req),
        .empty   (empty),
        .pop     (pop),
        .res     (res),
        .errors  (errors),
        .pending (pending)
    );

    // clock and reset
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        rst_n = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
    end

    // watchdog
    initial
    begin
        #3000000;
        $display("x86_64_instruction_encoder_unit test failed");
        $finish;
    end

    function automatic req_t make_request(input logic [4:0] op, input logic [3:0] r1,
                                          input logic [3:0] r2, input logic [2:0] xmm,
                                          input logic [31:0] disp, input logic [63:0] imm,
                                          input logic [7:0] cond);
        req_t r;
        r.req_type     = op;
        r.reg_first    = r1;
        r.reg_second   = r2;
        r.xmm_number   = xmm;
        r.displacement = disp;
        r.immediate    = imm;
        r.condition    = cond;
        return r;
    endfunction

    // displacement biased toward the mod field boundaries
    function automatic logic [31:0] random_disp();
        case ($urandom_range(0, 5))
            0: return 32'd0;
            1: return $urandom_range(0, 255) - 128;
            2:
            begin
                case ($urandom_range(0, 3))
                    0: return 32'd127;
                    1: return -32'sd128;
                    2: return 32'd128;
                    default: return -32'sd129;
                endcase
            end
            default: return $urandom;
        endcase
    endfunction

    function automatic req_t random_request();
        int          pick;
        logic [4:0]  op;
        logic [7:0]  cond;
        pick = $urandom_range(0, 99);
        if (pick < 3)
            op = OP_CLEAR;
        else if (pick < 6)
            op = 5'($urandom_range(26, 31));
        else
            op = 5'($urandom_range(0, 24));
        if ($urandom_range(0, 3) == 0)
            cond = 8'($urandom_range(0, 255));
        else
            cond = 8'h80 | 8'($urandom_range(0, 15));
        return make_request(op, 4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)),
                            3'($urandom_range(0, 7)), random_disp(), {$urandom, $urandom},
                            cond);
    endfunction

    // one request transfer, after a random gap
    task automatic send(input req_t r);
        int gap;
        gap = sender_calm ? 0 : $urandom_range(0, 6);
        if (gap > 0)
        begin
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        push <= 1'b1;
        req  <= r;
        do
            @(posedge clk);
        while (full);
    endtask

    // result side: random stall before each transfer
    initial
    begin : drain
        int stall;
        int popped;
        pop           = 1'b0;
        receiver_calm = 1'b0;
        popped        = 0;
        while (rst_n !== 1'b1) @(posedge clk);
        forever
        begin
            if (popped % 50 == 0)
                receiver_calm = ($urandom_range(0, 2) == 0);
            stall = receiver_calm ? 0 : $urandom_range(0, 6);
            if (stall > 0)
            begin
                pop <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            pop <= 1'b1;
            do
                @(posedge clk);
            while (empty);
            popped++;
        end
    end

    // request side and verdict
    initial
    begin : stim
        int limit;
        push        = 1'b0;
        req         = '0;
        sender_calm = 1'b0;
        while (rst_n !== 1'b1) @(posedge clk);

        // directed: register extremes, every mod form, sib bases, xmm bases above r7
        send(make_request(OP_PUSH,      4'd15, 4'd0,  3'd0, 32'd0,        64'd0,   8'h80));
        send(make_request(OP_POP,       4'd0,  4'd15, 3'd7, 32'd0,        64'd0,   8'h80));
        send(make_request(OP_MOV_IMM64, 4'd9,  4'd0,  3'd0, 32'd0,        '1,      8'h80));
        send(make_request(OP_MOV_RR,    4'd15, 4'd8,  3'd0, 32'd0,        64'd0,   8'h80));
        send(make_request(OP_TEST_RR,   4'd3,  4'd12, 3'd0, 32'd0,        64'd0,   8'h80));
        send(make_request(OP_CMP_RR,    4'd8,  4'd1,  3'd0, 32'd0,        64'd0,   8'h80));
        send(make_request(OP_XOR_RR,    4'd0,  4'd0,  3'd0, 32'd0,        64'd0,   8'h80));
        send(make_request(OP_LOAD,      4'd10, 4'd4,  3'd0, 32'd0,        64'd0,   8'h80));
        send(make_request(OP_LOAD,      4'd1,  4'd13, 3'd0, 32'd0,        64'd0,   8'h80));
        send(make_request(OP_STORE,     4'd12, 4'd9,  3'd0, 32'd127,      64'd0,   8'h80));
        send(make_request(OP_STORE,     4'd5,  4'd2,  3'd0, -32'sd128,    64'd0,   8'h80));
        send(make_request(OP_MOVUPS_LD, 4'd12, 4'd0,  3'd7, 32'd128,      64'd0,   8'h80));
        send(make_request(OP_MOVUPS_ST, 4'd9,  4'd0,  3'd0, -32'sd129,    64'd0,   8'h80));
        send(make_request(OP_MOVQ_LD,   4'd5,  4'd0,  3'd3, 32'd0,        64'd0,   8'h80));
        send(make_request(OP_MOVQ_ST,   4'd4,  4'd0,  3'd5, 32'h7FFFFFFF, 64'd0,   8'h80));
        send(make_request(OP_MOV_MI32,  4'd15, 4'd0,  3'd0, 32'h80000000,
                          64'hDEADBEEF_12345678, 8'h80));
        send(make_request(OP_ADD_I32,   4'd11, 4'd0,  3'd0, 32'd0,        '1,      8'h80));
        send(make_request(OP_SUB_I32,   4'd6,  4'd0,  3'd0, 32'd0,        64'h80000001, 8'h80));
        send(make_request(OP_CMP_MI32,  4'd13, 4'd0,  3'd0, 32'd1,        64'd7,   8'h80));
        send(make_request(OP_INC_MEM,   4'd8,  4'd0,  3'd0, 32'd0,        64'd0,   8'h80));
        send(make_request(OP_CALL_R,    4'd14, 4'd0,  3'd0, 32'd0,        64'd0,   8'h80));
        send(make_request(OP_JMP_REL,   4'd0,  4'd0,  3'd0, '1,           64'd0,   8'h80));
        send(make_request(OP_JCC_REL,   4'd0,  4'd0,  3'd0, 32'h12345678, 64'd0,   8'h00));
        send(make_request(OP_JCC_REL,   4'd0,  4'd0,  3'd0, 32'd0,        64'd0,   8'hFF));
        send(make_request(OP_JMP_ABS,   4'd0,  4'd0,  3'd0, 32'd0,
                          64'hFEDCBA98_76543210, 8'h80));
        send(make_request(OP_PAUSE,     4'd0,  4'd0,  3'd0, 32'd0,        64'd0,   8'h80));
        send(make_request(OP_RET,       4'd0,  4'd0,  3'd0, 32'd0,        64'd0,   8'h80));
        send(make_request(OP_INT3,      4'd0,  4'd0,  3'd0, 32'd0,        64'd0,   8'h80));
        // offset clear and codes past the last request are silent
        send(make_request(OP_CLEAR,     4'd0,  4'd0,  3'd0, 32'd0,        64'd0,   8'h80));
        send(make_request(5'd26,        4'd0,  4'd0,  3'd0, 32'd0,        64'd0,   8'h80));
        send(make_request(5'd31,        4'd15, 4'd15, 3'd7, '1,           '1,      8'hFF));
        send(make_request(OP_RET,       4'd0,  4'd0,  3'd0, 32'd0,        64'd0,   8'h80));

        // random requests in stretches with and without gaps
        for (int k = 0; k < RANDOM_REQUESTS; k++)
        begin
            if (k % 40 == 0)
                sender_calm = ($urandom_range(0, 2) == 0);
            send(random_request());
        end
        push <= 1'b0;

        // drain, then let any stray byte show up
        @(posedge clk);
        limit = 0;
        while (pending != 0 && limit < 200000)
        begin
            @(posedge clk);
            limit++;
        end
        repeat (20) @(posedge clk);
        if (errors == 0 && pending == 0)
            $display("x86_64_instruction_encoder_unit test passed");
        else
            $display("x86_64_instruction_encoder_unit test failed");
        $finish;
    end

endmodule
